/* src/rau_pkg.sv */
package rau_pkg;

  // Operand width range and the fixed field width of the operand ports
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int MAX_W             = 32;
  localparam int FIELD_W           = 16;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 31;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // Product slots of the shared multiplier
  localparam logic [1:0] MUL_AB  = 2'd0;  // |an| * bd
  localparam logic [1:0] MUL_BA  = 2'd1;  // |bn| * ad
  localparam logic [1:0] MUL_DEN = 2'd2;  // result denominator
  localparam logic [1:0] MUL_NN  = 2'd3;  // |an| * |bn|

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        greater;
    logic                        less;
    logic                        equal;
    logic [1:0]                  status;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic [1:0] mul_sel;
    logic       add_go;
    logic       add_sum;
    logic       fix_go;
    logic       fix_cmp;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_write;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_den;
    logic div_zero;
    logic op_add;
    logic gcd_done;
  } dp_stat_t;

endpackage

/* src/rau_ctrl.sv */
module rau_ctrl #(
  parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             operands_valid,
  output logic             operands_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::cmd_t    cmd
);

  localparam int DIV_STEPS = 2 * W;
  localparam int CW        = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_FIX   = 8'b0000_1000,
    S_GINIT = 8'b0001_0000,
    S_GCD   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [1:0]    mul_cnt, mul_cnt_next;
  logic          pass, pass_next;
  logic [CW-1:0] div_cnt, div_cnt_next;
  logic          result_valid_next;

  assign operands_ready = (state == S_IDLE);

  always_comb begin
    cmd               = '0;
    state_next        = state;
    mul_cnt_next      = mul_cnt;
    pass_next         = pass;
    div_cnt_next      = div_cnt;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      S_IDLE: begin
        if (operands_valid) begin
          cmd.load     = 1'b1;
          mul_cnt_next = rau_pkg::MUL_AB;
          pass_next    = 1'b0;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.zero_den) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_go   = 1'b1;
          cmd.mul_sel  = mul_cnt;
          mul_cnt_next = mul_cnt + 2'd1;
          if (mul_cnt == rau_pkg::MUL_NN) begin
            state_next = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.add_go  = 1'b1;
        cmd.add_sum = pass;
        state_next  = S_FIX;
      end
      S_FIX: begin
        cmd.fix_go  = 1'b1;
        cmd.fix_cmp = !pass;
        priority if (pass) begin
          state_next = S_GINIT;
        end else if (stat.div_zero) begin
          state_next = S_DONE;
        end else if (stat.op_add) begin
          pass_next  = 1'b1;
          state_next = S_ADD;
        end else begin
          state_next = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + CW'(1);
        if (div_cnt == DIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_write     = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      mul_cnt      <= '0;
      pass         <= 1'b0;
      div_cnt      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      mul_cnt      <= mul_cnt_next;
      pass         <= pass_next;
      div_cnt      <= div_cnt_next;
    end
  end

endmodule

/* src/rau_dp.sv */
module rau_dp #(
  parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  rau_pkg::in_t      operands,
  input  rau_pkg::cmd_t     cmd,
  output rau_pkg::dp_stat_t stat,
  output rau_pkg::out_t     result
);

  localparam int NW = 2 * W;
  localparam int KW = $clog2(NW);
  localparam int ZW = rau_pkg::MAX_W;
  localparam int RW = (NW > rau_pkg::RES_NUM_W) ? NW : rau_pkg::RES_NUM_W;

  // Take the low W bits of a field and sign extend them by one bit
  function automatic logic signed [W:0] sext(input logic [rau_pkg::FIELD_W-1:0] f);
    logic [ZW-1:0] z;
    logic [W-1:0]  t;
    z = ZW'(f);
    t = z[W-1:0];
    return {t[W-1], t};
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W:0] x);
    logic [W:0] y;
    y = x[W] ? -x : x;
    return y[W-1:0];
  endfunction

  // Operand registers, denominators normalized positive
  logic [1:0]   op_r;
  logic         an_neg, bn_neg, zero_den;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;

  logic signed [W:0] an_s, ad_s, bn_s, bd_s, an_e, bn_e;

  always_comb begin
    an_s = sext(operands.a_num);
    ad_s = sext(operands.a_den);
    bn_s = sext(operands.b_num);
    bd_s = sext(operands.b_den);
    an_e = ad_s[W] ? -an_s : an_s;
    bn_e = bd_s[W] ? -bn_s : bn_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= operands.operation;
      an_neg   <= an_e[W];
      an_mag   <= mag(an_e);
      ad_mag   <= mag(ad_s);
      bn_neg   <= bn_e[W];
      bn_mag   <= mag(bn_e);
      bd_mag   <= mag(bd_s);
      zero_den <= (ad_s == '0) || (bd_s == '0);
    end
  end

  // Shared multiplier, one product a cycle
  logic [W-1:0]  ma, mb;
  logic [NW-1:0] prod, p_ab, p_ba, p_den, p_nn;

  always_comb begin
    unique case (cmd.mul_sel)
      rau_pkg::MUL_AB:  begin ma = an_mag; mb = bd_mag; end
      rau_pkg::MUL_BA:  begin ma = bn_mag; mb = ad_mag; end
      rau_pkg::MUL_DEN: begin
        ma = ad_mag;
        mb = (op_r == rau_pkg::OP_DIV) ? bn_mag : bd_mag;
      end
      rau_pkg::MUL_NN:  begin ma = an_mag; mb = bn_mag; end
    endcase
    prod = NW'(ma) * NW'(mb);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      unique case (cmd.mul_sel)
        rau_pkg::MUL_AB:  p_ab  <= prod;
        rau_pkg::MUL_BA:  p_ba  <= prod;
        rau_pkg::MUL_DEN: p_den <= prod;
        rau_pkg::MUL_NN:  p_nn  <= prod;
      endcase
    end
  end

  // Sign-magnitude adder: raw add or subtract, then sign fix
  logic          add_bneg_in, add_same, add_aneg, add_bneg;
  logic [NW:0]   add_r, fix_full;
  logic          borrow, fneg;
  logic [NW-1:0] fmag, s_mag;
  logic          s_neg, greater_r, less_r, equal_r;

  always_comb begin
    add_bneg_in = cmd.add_sum ? bn_neg : !bn_neg;
    borrow      = !add_same && add_r[NW];
    fix_full    = borrow ? -add_r : add_r;
    fmag        = fix_full[NW-1:0];
    fneg        = (borrow ? add_bneg : add_aneg) && (fmag != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.add_go) begin
      add_same <= (an_neg == add_bneg_in);
      add_aneg <= an_neg;
      add_bneg <= add_bneg_in;
      add_r    <= (an_neg == add_bneg_in) ? ({1'b0, p_ab} + {1'b0, p_ba})
                                          : ({1'b0, p_ab} - {1'b0, p_ba});
    end
    if (cmd.fix_go) begin
      s_neg <= fneg;
      s_mag <= fmag;
      if (cmd.fix_cmp) begin
        greater_r <= !fneg && (fmag != '0);
        less_r    <= fneg;
        equal_r   <= (fmag == '0);
      end
    end
  end

  // Binary gcd, one step a cycle
  logic          n_sel_neg, n_neg;
  logic [NW-1:0] n_sel_mag, n_mag, u, v, u_next, v_next, dif;
  logic [KW-1:0] k, k_next;
  logic          ge_uv;

  always_comb begin
    unique case (op_r)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        n_sel_neg = s_neg;
        n_sel_mag = s_mag;
      end
      rau_pkg::OP_MUL: begin
        n_sel_neg = an_neg ^ bn_neg;
        n_sel_mag = p_nn;
      end
      rau_pkg::OP_DIV: begin
        n_sel_neg = an_neg ^ bn_neg;
        n_sel_mag = p_ab;
      end
    endcase
  end

  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    ge_uv  = (u >= v);
    dif    = ge_uv ? (u - v) : (v - u);
    if (cmd.gcd_init) begin
      u_next = n_sel_mag;
      v_next = p_den;
      k_next = '0;
    end else if (cmd.gcd_step) begin
      priority if (!u[0] && !v[0]) begin
        u_next = u >> 1;
        v_next = v >> 1;
        k_next = k + KW'(1);
      end else if (!u[0]) begin
        u_next = u >> 1;
      end else if (!v[0]) begin
        v_next = v >> 1;
      end else if (ge_uv) begin
        u_next = dif >> 1;
      end else begin
        v_next = dif >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    u <= u_next;
    v <= v_next;
    k <= k_next;
    if (cmd.gcd_init) begin
      n_neg <= n_sel_neg && (n_sel_mag != '0);
      n_mag <= n_sel_mag;
    end
  end

  // Two-lane restoring divider: numerator and denominator by the gcd
  logic [NW-1:0] g, qn, qd, rn, rd;
  logic [NW:0]   rsn, rsd, rsn_sub, rsd_sub;
  logic          gen, ged;

  always_comb begin
    rsn     = {rn, qn[NW-1]};
    rsd     = {rd, qd[NW-1]};
    rsn_sub = rsn - {1'b0, g};
    rsd_sub = rsd - {1'b0, g};
    gen     = (rsn >= {1'b0, g});
    ged     = (rsd >= {1'b0, g});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g  <= v << k;
      qn <= n_mag;
      qd <= p_den;
      rn <= '0;
      rd <= '0;
    end else if (cmd.div_step) begin
      rn <= gen ? rsn_sub[NW-1:0] : rsn[NW-1:0];
      rd <= ged ? rsd_sub[NW-1:0] : rsd[NW-1:0];
      qn <= {qn[NW-2:0], gen};
      qd <= {qd[NW-2:0], ged};
    end
  end

  // Result assembly and output register
  logic          div_zero;
  logic [RW-1:0] m_ext, num_ext, den_ext;
  rau_pkg::out_t out_next;

  assign div_zero = (op_r == rau_pkg::OP_DIV) && (bn_mag == '0);

  always_comb begin
    m_ext    = RW'(qn);
    num_ext  = n_neg ? (~m_ext + RW'(1)) : m_ext;
    den_ext  = RW'(qd);
    out_next = '0;
    if (zero_den) begin
      out_next.status = rau_pkg::ST_ZERO_DEN;
    end else begin
      out_next.greater = greater_r;
      out_next.less    = less_r;
      out_next.equal   = equal_r;
      if (div_zero) begin
        out_next.status = rau_pkg::ST_DIV_ZERO;
      end else begin
        out_next.status  = rau_pkg::ST_OK;
        out_next.res_num = num_ext[rau_pkg::RES_NUM_W-1:0];
        out_next.res_den = den_ext[rau_pkg::RES_DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      result <= out_next;
    end
  end

  assign stat.zero_den = zero_den;
  assign stat.div_zero = div_zero;
  assign stat.op_add   = (op_r == rau_pkg::OP_ADD);
  assign stat.gcd_done = (u == '0);

endmodule

/* src/rational_arithmetic_unit.sv */
// Channel   Direction  Handshake                        Payload
// operands  in         operands_valid / operands_ready  rau_pkg::in_t
// result    out        result_valid / result_ready      rau_pkg::out_t
//
// One item is worked at a time; operands_ready is high only while the block is idle.
// A zero operand denominator ends the item before any product is formed, a divide by
// zero after the products and the first add pass. Otherwise an item has four products
// through one shared multiplier, one or two sign-magnitude add passes, the binary gcd
// loop (one step a cycle, data dependent) and 2*OPERAND_WIDTH restoring divide steps.
// Reset (rst, synchronous) returns the controller to idle and drops any pending item.
// The result register holds its item under a stall; the next item is accepted meanwhile.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          operands_valid,
  output logic          operands_ready,
  input  rau_pkg::in_t  operands,
  output logic          result_valid,
  input  logic          result_ready,
  output rau_pkg::out_t result
);

  // Commands down to the datapath, status back up
  rau_pkg::cmd_t     cmd;
  rau_pkg::dp_stat_t stat;

  // Sequence the item: load, multiply, add, reduce, divide, deliver
  rau_ctrl #(
    .W(OPERAND_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .operands_valid (operands_valid),
    .operands_ready (operands_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Hold operands, products, gcd state, quotients and the result item
  rau_dp #(
    .W(OPERAND_WIDTH)
  ) u_dp (
    .clk      (clk),
    .operands (operands),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

/* src/rau_checker.sv */
module rau_checker (
  input logic          clk,
  input logic          rst,
  input logic          operands_valid,
  input logic          operands_ready,
  input logic          result_valid,
  input logic          result_ready,
  input rau_pkg::out_t result
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result item dropped under stall");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result item changed under stall");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    operands_valid && operands_ready |=> !operands_ready)
    else $error("operands accepted while an item is in work");

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != rau_pkg::ST_ZERO_DEN)
      |-> $onehot({result.greater, result.less, result.equal}))
    else $error("compare flags not exactly one");

  a_zero_den_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == rau_pkg::ST_ZERO_DEN)
      |-> (result.res_num == '0) && (result.res_den == '0)
          && !result.greater && !result.less && !result.equal)
    else $error("zero denominator item carries data");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

/* test/rational_arithmetic_unit_tb.sv */
module rational_arithmetic_unit_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic operands_valid = 1'b0;
  logic operands_ready;
  rau_pkg::in_t operands = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  rau_pkg::out_t result;

  rational_arithmetic_unit DUT (
    .clk(clk),
    .rst(rst),
    .operands_valid(operands_valid),
    .operands_ready(operands_ready),
    .operands(operands),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // Idle rates in percent, changed per phase of the random run.
  int send_idle = 32;
  int recv_idle = 54;

  // Blocking copy of what operands_valid is driven to, so that valid is
  // only lowered when it is actually high.
  bit valid_hi = 1'b0;

  rau_pkg::out_t pending_results[$];
  int items_sent = 0;
  int directed_items = 0;
  int results_checked = 0;
  int error_count = 0;
  int recv_stall_left = 0;

  // 2 time unit clock period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact rational result, reduced, with the compare flags. All products
  // and sums of 16-bit operands fit a longint, so plain signed arithmetic
  // gives the exact value before reduction.
  function automatic rau_pkg::out_t predict_rational(rau_pkg::in_t it);
    longint an, ad, bn, bd, lhs, rhs, nm, dm, mag, x, y, t, q;
    rau_pkg::out_t r;
    r = '0;
    an = longint'($signed(it.a_num));
    ad = longint'($signed(it.a_den));
    bn = longint'($signed(it.b_num));
    bd = longint'($signed(it.b_den));
    if (ad == 0 || bd == 0) begin
      // A zero denominator wins over everything else; all other fields stay 0.
      r.status = rau_pkg::ST_ZERO_DEN;
      return r;
    end
    // Move each operand's sign into its numerator.
    if (ad < 0) begin
      ad = -ad;
      an = -an;
    end
    if (bd < 0) begin
      bd = -bd;
      bn = -bn;
    end
    lhs = an * bd;
    rhs = bn * ad;
    r.greater = (lhs > rhs);
    r.less = (lhs < rhs);
    r.equal = (lhs == rhs);
    if (it.operation == rau_pkg::OP_DIV && bn == 0) begin
      r.status = rau_pkg::ST_DIV_ZERO;
      return r;
    end
    dm = ad * bd;
    case (it.operation)
      rau_pkg::OP_ADD: nm = an * bd + bn * ad;
      rau_pkg::OP_SUB: nm = an * bd - bn * ad;
      rau_pkg::OP_MUL: nm = an * bn;
      default: begin
        nm = an * bd;
        dm = ad * bn;
        if (dm < 0) begin
          dm = -dm;
          nm = -nm;
        end
      end
    endcase
    mag = (nm < 0) ? -nm : nm;
    // Euclid on the magnitudes; a zero numerator reduces to 0/1.
    x = mag;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    q = nm / x;
    r.res_num = q[rau_pkg::RES_NUM_W-1:0];
    q = dm / x;
    r.res_den = q[rau_pkg::RES_DEN_W-1:0];
    r.status = rau_pkg::ST_OK;
    return r;
  endfunction

  // Receiver: random per-cycle stalls, now and then a long one so that
  // stalls overlap every stage of the next item's work.
  always @(negedge clk) begin
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      result_ready <= 1'b0;
    end else if (recv_idle > 0 && $urandom_range(99) < 2) begin
      recv_stall_left = $urandom_range(10, 100);
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Checker: sample both handshakes at the rising edge. Retire a result
  // before queueing a new item, since a result accepted at the same edge
  // always belongs to an older item.
  always @(posedge clk) begin
    rau_pkg::out_t exp_res;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no item pending");
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (result.res_num !== exp_res.res_num) begin
            $error("res_num: expected %0d, got %0d", exp_res.res_num, result.res_num);
            error_count++;
          end
          if (result.res_den !== exp_res.res_den) begin
            $error("res_den: expected %0d, got %0d", exp_res.res_den, result.res_den);
            error_count++;
          end
          if (result.greater !== exp_res.greater) begin
            $error("greater: expected %0d, got %0d", exp_res.greater, result.greater);
            error_count++;
          end
          if (result.less !== exp_res.less) begin
            $error("less: expected %0d, got %0d", exp_res.less, result.less);
            error_count++;
          end
          if (result.equal !== exp_res.equal) begin
            $error("equal: expected %0d, got %0d", exp_res.equal, result.equal);
            error_count++;
          end
          if (result.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, result.status);
            error_count++;
          end
        end
      end
      if (operands_valid && operands_ready) begin
        pending_results.push_back(predict_rational(operands));
        items_sent++;
      end
    end
  end

  // Send one item. Enter and leave at a falling edge. After acceptance,
  // either keep valid high for a back-to-back item or drop it for a gap.
  task automatic send_item(input logic [1:0] op, input logic signed [15:0] an,
                           input logic signed [15:0] ad, input logic signed [15:0] bn,
                           input logic signed [15:0] bd);
    rau_pkg::in_t it;
    int gap;
    it.operation = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    operands <= it;
    operands_valid <= 1'b1;
    valid_hi = 1'b1;
    do @(posedge clk); while (!operands_ready);
    @(negedge clk);
    if ($urandom_range(99) < send_idle) begin
      operands_valid <= 1'b0;
      valid_hi = 1'b0;
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every expected result has come.
  task automatic drain_results();
    if (valid_hi) begin
      operands_valid <= 1'b0;
      valid_hi = 1'b0;
    end
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_field_extremes();
    send_item(rau_pkg::OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(rau_pkg::OP_ADD, -16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff);
    send_item(rau_pkg::OP_SUB, 16'sh7fff, -16'sd32768, -16'sd32768, 16'sh7fff);
    send_item(rau_pkg::OP_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(rau_pkg::OP_MUL, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1);
    send_item(rau_pkg::OP_DIV, -16'sd32768, 16'sd1, 16'sd1, -16'sd32768);
    send_item(rau_pkg::OP_DIV, 16'sh7fff, -16'sd1, -16'sd32768, 16'sh7fff);
    send_item(rau_pkg::OP_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
    directed_items += 8;
  endtask

  task automatic test_each_operation();
    send_item(rau_pkg::OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(rau_pkg::OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(rau_pkg::OP_MUL, 16'sd6, -16'sd4, 16'sd10, 16'sd9);
    send_item(rau_pkg::OP_DIV, -16'sd3, 16'sd8, -16'sd9, -16'sd4);
    send_item(rau_pkg::OP_DIV, 16'sd5, 16'sd7, -16'sd10, 16'sd21);
    directed_items += 5;
  endtask

  task automatic test_zero_denominator();
    send_item(rau_pkg::OP_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2);
    send_item(rau_pkg::OP_MUL, 16'sd3, 16'sd5, 16'sd1, 16'sd0);
    // Zero denominator takes precedence over divide by zero.
    send_item(rau_pkg::OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    directed_items += 3;
  endtask

  task automatic test_divide_by_zero();
    send_item(rau_pkg::OP_DIV, 16'sd7, 16'sd3, 16'sd0, 16'sd5);
    send_item(rau_pkg::OP_DIV, -16'sd7, -16'sd3, 16'sd0, -16'sd1);
    directed_items += 2;
  endtask

  task automatic test_zero_and_equal();
    // Zero results come back as 0/1.
    send_item(rau_pkg::OP_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7);
    send_item(rau_pkg::OP_SUB, 16'sd3, 16'sd6, -16'sd1, -16'sd2);
    send_item(rau_pkg::OP_MUL, 16'sd0, -16'sd9, 16'sd4, 16'sd3);
    // Equal values in different forms.
    send_item(rau_pkg::OP_DIV, 16'sd3, 16'sd6, -16'sd1, -16'sd2);
    directed_items += 4;
  endtask

  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6: return 16'($signed($urandom_range(0, 40)) - 20);
      7: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return -16'sd32768;
          2: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      // Values with shared factors so reduction has work to do.
      default: return 16'(($signed($urandom_range(1, 60)) - 30) << $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_denominator();
    logic signed [15:0] v;
    if ($urandom_range(99) < 3) return 16'sd0;
    v = pick_operand();
    return (v == 0) ? 16'sd1 : v;
  endfunction

  // Random items, mostly with nonzero denominators; half way through,
  // hold the sender until the block has emptied.
  task automatic test_random_items(input int count, input int s_idle, input int r_idle);
    logic [1:0] op;
    logic signed [15:0] an, ad, bn, bd;
    longint k, sn, sd;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      op = 2'($urandom_range(3));
      an = pick_operand();
      ad = pick_denominator();
      bn = pick_operand();
      bd = pick_denominator();
      if ($urandom_range(9) == 0) begin
        // Scale a to get an equal operand b.
        k = longint'($urandom_range(1, 4));
        if ($urandom_range(1)) k = -k;
        sn = longint'(an) * k;
        sd = longint'(ad) * k;
        if (sn >= -32768 && sn <= 32767 && sd >= -32768 && sd <= 32767) begin
          bn = 16'(sn);
          bd = 16'(sd);
        end
      end
      if (op == rau_pkg::OP_DIV && $urandom_range(19) == 0) bn = 16'sd0;
      send_item(op, an, ad, bn, bd);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_field_extremes();
    test_each_operation();
    test_zero_denominator();
    test_divide_by_zero();
    test_zero_and_equal();
    test_random_items(167, 32, 54);
    test_random_items(167, 54, 32);
    test_random_items(166, 0, 0);
    drain_results();
    // Watch a while longer for stray results.
    repeat (150) @(posedge clk);
    $display("run covered %0d items (%0d directed) over three idle mixes", items_sent,
             directed_items);
    $display("%0d results checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
src/rau_pkg.sv
src/rau_ctrl.sv
src/rau_dp.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
test/rational_arithmetic_unit_tb.sv
